// File: sv/byte_ring_deque_core_defines.svh
// Assertion macros shared by the byte ring deque RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef BYTE_RING_DEQUE_CORE_DEFINES_SVH
`define BYTE_RING_DEQUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BRD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("byte ring deque check failed");
`define BRD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("byte ring deque check failed");
`else
`define BRD_ASSERT(lbl, clk, rst_n, prop)
`define BRD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/brd_pkg.sv
// Shared types and constants of the byte ring deque.
// Depends on nothing; used by the controller, the datapath and the top level.
package brd_pkg;

  localparam int REQ_W    = 3;
  localparam int DATA_W   = 8;
  localparam int CAP_W    = 9;
  localparam int FILL_W   = 9;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [REQ_W-1:0] REQ_PUT_TAIL  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUT_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLUSH     = 3'd4;

  localparam logic [0:0]       REG_CAPACITY  = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET     = 9'd256;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// File: sv/brd_ctrl.sv
// Sequencing state machine of the byte ring deque.
// Depends on brd_pkg and the assertion macros; drives the datapath commands.
`include "byte_ring_deque_core_defines.svh"
module brd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output brd_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_OUT) && out_ready);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BRD_ASSERT(a_accept_exec, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_EXEC))
  `BRD_ASSERT(a_result_follows, clk, rst_n, $rose(out_valid) |-> $past(cmd.exec))
endmodule

// File: sv/brd_dp.sv
// Datapath of the byte ring deque: slot store, indices, count, capacity register.
// Depends on brd_pkg and the assertion macros; steered by brd_ctrl commands.
`include "byte_ring_deque_core_defines.svh"
module brd_dp #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brd_pkg::ctrl_cmd_t           cmd,
  input  logic [brd_pkg::REQ_W-1:0]    req_type,
  input  logic [brd_pkg::DATA_W-1:0]   data_byte,
  input  logic                         cfg_wr,
  input  logic [brd_pkg::CAP_W-1:0]    cfg_wdata,
  output logic [brd_pkg::CAP_W-1:0]    cap_value,
  output logic                         ok,
  output logic [brd_pkg::DATA_W-1:0]   data_out,
  output logic [brd_pkg::FILL_W-1:0]   fill_count
);

  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);
  localparam int CW  = (CNW > brd_pkg::CAP_W) ? CNW : brd_pkg::CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [brd_pkg::DATA_W-1:0] mem [DEPTH];

  logic [brd_pkg::REQ_W-1:0]  req_r;
  logic [brd_pkg::DATA_W-1:0] byte_r;
  logic [brd_pkg::CAP_W-1:0]  cap_r;
  logic [IW-1:0]              head_r, head_nxt;
  logic [IW-1:0]              tail_r, tail_nxt;
  logic [CNW-1:0]             cnt_r, cnt_nxt;
  logic                       ok_r, ok_nxt;
  logic                       hit_r, hit_nxt;
  logic [brd_pkg::FILL_W-1:0] fill_r;
  logic [brd_pkg::DATA_W-1:0] rd_data_r;

  logic [CW-1:0] cap_raw, cap_eff, cap_m1, head_ext, tail_ext, cnt_ext, cnt_nxt_ext;
  logic [IW-1:0] head_inc, head_dec, tail_inc, waddr;
  logic          not_full, not_empty, we;

  assign cap_raw  = CW'(cap_r);
  assign head_ext = CW'(head_r);
  assign tail_ext = CW'(tail_r);
  assign cnt_ext  = CW'(cnt_r);

  always_comb begin
    priority if (cap_raw == '0) begin
      cap_eff = CW'(1);
    end else if (cap_raw > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign cap_m1    = cap_eff - CW'(1);
  assign not_full  = cnt_ext < cap_eff;
  assign not_empty = (cnt_r != '0);
  assign tail_inc  = ((tail_ext + CW'(1)) >= cap_eff) ? '0 : tail_r + IW'(1);
  assign head_inc  = ((head_ext + CW'(1)) >= cap_eff) ? '0 : head_r + IW'(1);
  assign head_dec  = (head_r == '0) ? cap_m1[IW-1:0] : head_r - IW'(1);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    ok_nxt   = 1'b0;
    hit_nxt  = 1'b0;
    we       = 1'b0;
    waddr    = tail_r;
    unique case (req_r)
      brd_pkg::REQ_PUT_TAIL: begin
        if (not_full) begin
          we       = 1'b1;
          tail_nxt = tail_inc;
          cnt_nxt  = cnt_r + CNW'(1);
          ok_nxt   = 1'b1;
        end
      end
      brd_pkg::REQ_PUT_FRONT: begin
        if (not_full) begin
          we       = 1'b1;
          waddr    = head_dec;
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + CNW'(1);
          ok_nxt   = 1'b1;
        end
      end
      brd_pkg::REQ_POP: begin
        if (not_empty) begin
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - CNW'(1);
          ok_nxt   = 1'b1;
          hit_nxt  = 1'b1;
        end
      end
      brd_pkg::REQ_PEEK: begin
        if (not_empty) begin
          ok_nxt  = 1'b1;
          hit_nxt = 1'b1;
        end
      end
      brd_pkg::REQ_FLUSH: begin
        tail_nxt = head_r;
        cnt_nxt  = '0;
        ok_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cnt_nxt_ext = CW'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= brd_pkg::CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (cfg_wr) begin
      cap_r  <= cfg_wdata;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      byte_r <= data_byte;
    end
    if (cmd.exec) begin
      ok_r   <= ok_nxt;
      hit_r  <= hit_nxt;
      fill_r <= cnt_nxt_ext[brd_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= byte_r;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign cap_value  = cap_r;
  assign ok         = ok_r;
  assign data_out   = hit_r ? rd_data_r : '0;
  assign fill_count = fill_r;

  `BRD_ASSERT(a_cnt_in_cap, clk, rst_n, cnt_ext <= cap_eff)
  `BRD_ASSERT(a_idx_in_cap, clk, rst_n, (head_ext < cap_eff) && (tail_ext < cap_eff))
  `BRD_ASSERT(a_ring_meet, clk, rst_n, ((cnt_r == '0) || (cnt_ext == cap_eff)) |-> (head_r == tail_r))
endmodule

// File: sv/byte_ring_deque_core.sv
// Byte ring deque: an accepted request is executed in the execute state, and its
// result is then held in the output state until it is taken. A new request is
// taken in the cycle its predecessor's result is taken, so requests do not overlap;
// the slot store has a registered read port, read in the execute state. Reset is
// synchronous, active low: it empties the queue and sets the capacity to 256; the slot store is not cleared.
module byte_ring_deque_core #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [brd_pkg::REQ_W-1:0]    in_req_type,
  input  logic [brd_pkg::DATA_W-1:0]   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [brd_pkg::DATA_W-1:0]   out_data_out,
  output logic [brd_pkg::FILL_W-1:0]   out_fill_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brd_pkg::APB_AW-1:0]   paddr,
  input  logic [brd_pkg::APB_DW-1:0]   pwdata,
  output logic [brd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  brd_pkg::ctrl_cmd_t            cmd;
  logic                          cfg_wr;
  logic [brd_pkg::CAP_W-1:0]     cap_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == brd_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == brd_pkg::REG_CAPACITY) ?
                  brd_pkg::APB_DW'(cap_value) : '0;

  brd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  brd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .req_type   (in_req_type),
    .data_byte  (in_data_byte),
    .cfg_wr     (cfg_wr),
    .cfg_wdata  (pwdata[brd_pkg::CAP_W-1:0]),
    .cap_value  (cap_value),
    .ok         (out_ok),
    .data_out   (out_data_out),
    .fill_count (out_fill_count)
  );

endmodule
